// ===== rtl/u2u_pkg.sv =====
// ----------------------------------------------------------------------------
// u2u_pkg: shared types and constants for the utf-8 to utf-16 transcoder
// Holds the decoder state, the per-byte batch of code units and the
// range check used on finished sequences.
// ----------------------------------------------------------------------------
package u2u_pkg;

  localparam int unsigned MaxUnits = 4;

  localparam logic [15:0] ReplacementUnit = 16'hFFFD;
  localparam logic [15:0] HighSurrBase    = 16'hD800;
  localparam logic [15:0] LowSurrBase     = 16'hDC00;
  localparam logic [20:0] SuppBase        = 21'h010000;
  localparam logic [20:0] MaxCodePoint    = 21'h10FFFF;
  localparam logic [20:0] MinTwoByte      = 21'h000080;
  localparam logic [20:0] MinThreeByte    = 21'h000800;
  localparam logic [20:0] SurrLow         = 21'h00D800;
  localparam logic [20:0] SurrHigh        = 21'h00DFFF;
  localparam logic [20:0] BmpMax          = 21'h00FFFF;

  // expected sequence lengths, zero means no sequence open
  localparam logic [2:0] SeqNone  = 3'd0;
  localparam logic [2:0] SeqTwo   = 3'd2;
  localparam logic [2:0] SeqThree = 3'd3;
  localparam logic [2:0] SeqFour  = 3'd4;

  typedef struct packed {
    logic [20:0] partial_value;
    logic [1:0]  bytes_held;
    logic [2:0]  sequence_length;
  } seq_state_t;

  // code units caused by one byte, in order, plus how many are valid
  typedef struct packed {
    logic [MaxUnits-1:0][15:0] units;
    logic [2:0]                count;
    logic                      eos;
  } unit_batch_t;

  // range check on a finished sequence
  function automatic logic value_ok(logic [2:0] len, logic [20:0] cp);
    logic ok;
    case (len)
      SeqTwo:   ok = (cp >= MinTwoByte);
      SeqThree: ok = (cp >= MinThreeByte) && !((cp >= SurrLow) && (cp <= SurrHigh));
      default:  ok = (cp >= SuppBase) && (cp <= MaxCodePoint);
    endcase
    return ok;
  endfunction

endpackage

// ===== rtl/utf8_byte_if.sv =====
// ----------------------------------------------------------------------------
// utf8_byte_if: byte stream channel
// Valid/ready channel carrying one utf-8 byte and an end-of-string mark.
// ----------------------------------------------------------------------------
interface utf8_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       end_of_string;

  modport source (output valid, output data_byte, output end_of_string, input ready);
  modport sink   (input valid, input data_byte, input end_of_string, output ready);
endinterface

// ===== rtl/utf16_unit_if.sv =====
// ----------------------------------------------------------------------------
// utf16_unit_if: code unit channel
// Valid/ready channel carrying one utf-16 code unit and its framing marks.
// ----------------------------------------------------------------------------
interface utf16_unit_if;
  logic        valid;
  logic        ready;
  logic [15:0] code_unit;
  logic        run_last;
  logic        string_end;

  modport source (output valid, output code_unit, output run_last, output string_end,
                  input ready);
  modport sink   (input valid, input code_unit, input run_last, input string_end,
                  output ready);
endinterface

// ===== rtl/u2u_decode.sv =====
// ----------------------------------------------------------------------------
// u2u_decode: per-byte decode logic
// From the held sequence state and one byte, works out the code units the
// byte causes and the state left for the next byte.
// ----------------------------------------------------------------------------
module u2u_decode (
  input  u2u_pkg::seq_state_t  state,
  input  logic [7:0]           data_byte,
  input  logic                 end_of_string,
  output u2u_pkg::seq_state_t  state_next,
  output u2u_pkg::unit_batch_t batch
);

  logic        is_cont;
  logic [2:0]  held_inc;
  logic [20:0] acc;
  logic [20:0] supp_off;
  logic        fresh;

  assign is_cont  = (data_byte[7:6] == 2'b10);
  assign held_inc = {1'b0, state.bytes_held} + 3'd1;
  assign acc      = {state.partial_value[14:0], data_byte[5:0]};
  assign supp_off = acc - u2u_pkg::SuppBase;

  // build the unit list; slots not written default to the replacement unit
  always_comb begin
    batch.units = {u2u_pkg::MaxUnits{u2u_pkg::ReplacementUnit}};
    batch.count = 3'd0;
    batch.eos   = end_of_string;
    state_next  = state;
    fresh       = 1'b1;

    // continue or break an open sequence
    if (state.sequence_length != u2u_pkg::SeqNone) begin
      if (is_cont) begin
        fresh = 1'b0;
        if (held_inc >= state.sequence_length) begin
          if (u2u_pkg::value_ok(state.sequence_length, acc)) begin
            if (acc <= u2u_pkg::BmpMax) begin
              batch.units[0] = acc[15:0];
              batch.count    = 3'd1;
            end else begin
              batch.units[0] = u2u_pkg::HighSurrBase + {6'd0, supp_off[19:10]};
              batch.units[1] = u2u_pkg::LowSurrBase + {6'd0, supp_off[9:0]};
              batch.count    = 3'd2;
            end
          end else begin
            batch.count = 3'd1;
          end
          state_next = '0;
        end else if (end_of_string) begin
          batch.count = held_inc;
          state_next  = '0;
        end else begin
          state_next.bytes_held    = held_inc[1:0];
          state_next.partial_value = acc;
        end
      end else begin
        batch.count = {1'b0, state.bytes_held};
        state_next  = '0;
      end
    end

    // byte read as the start of a new sequence
    if (fresh) begin
      if (data_byte[7] == 1'b0) begin
        batch.units[batch.count[1:0]] = {8'd0, data_byte};
        batch.count = batch.count + 3'd1;
      end else if (data_byte[7:5] == 3'b110) begin
        state_next.sequence_length = u2u_pkg::SeqTwo;
        state_next.partial_value   = {16'd0, data_byte[4:0]};
        state_next.bytes_held      = 2'd1;
      end else if (data_byte[7:4] == 4'b1110) begin
        state_next.sequence_length = u2u_pkg::SeqThree;
        state_next.partial_value   = {17'd0, data_byte[3:0]};
        state_next.bytes_held      = 2'd1;
      end else if (data_byte[7:3] == 5'b11110) begin
        state_next.sequence_length = u2u_pkg::SeqFour;
        state_next.partial_value   = {18'd0, data_byte[2:0]};
        state_next.bytes_held      = 2'd1;
      end else begin
        batch.count = batch.count + 3'd1;
      end
      // lead byte carrying the end mark is truncated at once
      if (end_of_string && (state_next.sequence_length != u2u_pkg::SeqNone)) begin
        batch.count = batch.count + 3'd1;
        state_next  = '0;
      end
    end
  end

endmodule

// ===== rtl/u2u_emit.sv =====
// ----------------------------------------------------------------------------
// u2u_emit: result buffer and unit sequencer
// Holds the batch of units from one byte and hands them out one per
// request, marking the last unit of the batch and of the string.
// ----------------------------------------------------------------------------
module u2u_emit (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  load,
  input  u2u_pkg::unit_batch_t  batch,
  output logic                  free,
  utf16_unit_if.source          unit_out
);

  logic                              valid;
  logic [u2u_pkg::MaxUnits-1:0][15:0] units;
  logic [2:0]                        cnt;
  logic [1:0]                        idx;
  logic                              eos;
  logic                              take;
  logic                              last;

  assign take = unit_out.valid && unit_out.ready;
  assign last = ({1'b0, idx} == (cnt - 3'd1));
  assign free = !valid || (take && last);

  // output channel
  assign unit_out.valid      = valid;
  assign unit_out.code_unit  = units[idx];
  assign unit_out.run_last   = last;
  assign unit_out.string_end = last && eos;

  // buffer occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (load) begin
      valid <= 1'b1;
    end else if (take && last) begin
      valid <= 1'b0;
    end
  end

  // batch payload and unit index
  always_ff @(posedge clk) begin
    if (load) begin
      units <= batch.units;
      cnt   <= batch.count;
      eos   <= batch.eos;
      idx   <= 2'd0;
    end else if (take) begin
      idx <= idx + 2'd1;
    end
  end

  a_idx_in_range: assert property (@(posedge clk) disable iff (rst)
    valid |-> (cnt != 3'd0) && ({1'b0, idx} < cnt))
    else $error("unit index beyond batch count");

  a_load_only_when_free: assert property (@(posedge clk) disable iff (rst)
    load |-> free)
    else $error("batch loaded over undelivered units");

  a_stall_holds_unit: assert property (@(posedge clk) disable iff (rst)
    (valid && !unit_out.ready) |=> valid && $stable(idx) && $stable(unit_out.code_unit))
    else $error("stalled unit changed");

endmodule

// ===== rtl/utf8_to_utf16_transcoder.sv =====
// ----------------------------------------------------------------------------
// utf8_to_utf16_transcoder: streaming utf-8 to utf-16 converter
// Each byte passes the input register and is decoded into the unit buffer.
// Throughput: one byte per cycle while each byte yields at most one unit and
// unit_out is ready; a byte yielding more holds the input at the unit buffer.
// Reset (synchronous, rst high): no sequence open, both stages empty.
// ----------------------------------------------------------------------------
module utf8_to_utf16_transcoder (
  input  logic         clk,
  input  logic         rst,
  utf8_byte_if.sink    byte_in,
  utf16_unit_if.source unit_out
);

  logic                 in_valid;
  logic [7:0]           in_byte;
  logic                 in_eos;
  logic                 free;
  logic                 advance;
  u2u_pkg::seq_state_t  seq_state;
  u2u_pkg::seq_state_t  seq_state_next;
  u2u_pkg::unit_batch_t batch;

  assign advance       = in_valid && free;
  assign byte_in.ready = !in_valid || free;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (byte_in.valid && byte_in.ready) begin
      in_valid <= 1'b1;
    end else if (advance) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (byte_in.valid && byte_in.ready) begin
      in_byte <= byte_in.data_byte;
      in_eos  <= byte_in.end_of_string;
    end
  end

  // open sequence state
  always_ff @(posedge clk) begin
    if (rst) begin
      seq_state <= '0;
    end else if (advance) begin
      seq_state <= seq_state_next;
    end
  end

  u2u_decode u_decode (
    .state         (seq_state),
    .data_byte     (in_byte),
    .end_of_string (in_eos),
    .state_next    (seq_state_next),
    .batch         (batch)
  );

  u2u_emit u_emit (
    .clk      (clk),
    .rst      (rst),
    .load     (advance && (batch.count != 3'd0)),
    .batch    (batch),
    .free     (free),
    .unit_out (unit_out)
  );

  a_seq_len_legal: assert property (@(posedge clk) disable iff (rst)
    (seq_state.sequence_length == u2u_pkg::SeqNone) ||
    (seq_state.sequence_length == u2u_pkg::SeqTwo) ||
    (seq_state.sequence_length == u2u_pkg::SeqThree) ||
    (seq_state.sequence_length == u2u_pkg::SeqFour))
    else $error("illegal sequence length");

  a_held_below_len: assert property (@(posedge clk) disable iff (rst)
    (seq_state.sequence_length != u2u_pkg::SeqNone) |->
      (seq_state.bytes_held != 2'd0) &&
      ({1'b0, seq_state.bytes_held} < seq_state.sequence_length))
    else $error("held byte count out of range");

  a_closed_after_end: assert property (@(posedge clk) disable iff (rst)
    (advance && in_eos) |=> (seq_state.sequence_length == u2u_pkg::SeqNone))
    else $error("sequence left open after end of string");

endmodule

// ===== sim/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: testbench for the utf-8 to utf-16 transcoder
// Feeds byte strings through the byte channel and checks every code unit
// against an in-bench decoder. Covers valid and invalid sequences, then
// random strings under several idling patterns, a long receiver hold-off
// and a sender pause in the middle of an open sequence.
// ----------------------------------------------------------------------------
module tb;
  import u2u_pkg::*;

  typedef struct packed {
    logic [15:0] code_unit;
    logic        run_last;
    logic        string_end;
  } unit_rec_t;

  logic clk;
  logic rst;

  utf8_byte_if  byte_in ();
  utf16_unit_if unit_out ();

  utf8_to_utf16_transcoder DUT (
    .clk      (clk),
    .rst      (rst),
    .byte_in  (byte_in),
    .unit_out (unit_out)
  );

  // decoder state mirrored in the bench
  logic [20:0] acc_value;
  logic [1:0]  acc_held;
  logic [2:0]  acc_len;

  unit_rec_t pending_units[$];
  int        mismatches;
  int        bytes_sent;
  int        send_idle_pct;
  int        stall_pct;
  int        hold_req;
  int        hold_cnt;

  // clock
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // run limit
  initial begin
    #5_000_000;
    $display("tb failed");
    $finish;
  end

  task automatic report_mismatch(input string msg);
    $display("mismatch at %0t ns: %s", $time, msg);
    mismatches++;
  endtask

  function automatic void clear_sequence();
    acc_value = '0;
    acc_held  = '0;
    acc_len   = SeqNone;
  endfunction

  // expected code units for one accepted byte request
  function automatic void transcode_byte(input logic [7:0] b, input logic eos);
    logic [15:0] units[$];
    logic [2:0]  held;
    logic [20:0] offset;
    logic [20:0] min_cp;
    logic        in_range;
    logic        fresh;
    unit_rec_t   rec;
    int          n_units;
    int          k;
    fresh = 1'b1;
    if (acc_len != SeqNone) begin
      if (b[7:6] == 2'b10) begin
        // continuation byte extends the open sequence
        held = {1'b0, acc_held} + 3'd1;
        acc_value = {acc_value[14:0], b[5:0]};
        fresh = 1'b0;
        if (held >= acc_len) begin
          min_cp = (acc_len == SeqTwo) ? MinTwoByte :
                   (acc_len == SeqThree) ? MinThreeByte : SuppBase;
          in_range = (acc_value >= min_cp) && (acc_value <= MaxCodePoint) &&
                     !((acc_value >= SurrLow) && (acc_value <= SurrHigh));
          if (!in_range) begin
            units.push_back(ReplacementUnit);
          end else if (acc_value <= BmpMax) begin
            units.push_back(acc_value[15:0]);
          end else begin
            // supplementary plane: surrogate pair
            offset = acc_value - SuppBase;
            units.push_back(HighSurrBase + {6'd0, offset[19:10]});
            units.push_back(LowSurrBase + {6'd0, offset[9:0]});
          end
          clear_sequence();
        end else if (eos) begin
          // string ends inside the sequence
          repeat (held) units.push_back(ReplacementUnit);
          clear_sequence();
        end else begin
          acc_held = held[1:0];
        end
      end else begin
        // broken sequence, breaking byte is decoded again below
        repeat (acc_held) units.push_back(ReplacementUnit);
        clear_sequence();
      end
    end

    if (fresh) begin
      if (!b[7]) begin
        units.push_back({8'h00, b});
      end else if (b[7:5] == 3'b110) begin
        acc_len = SeqTwo;
        acc_value = {16'd0, b[4:0]};
        acc_held = 2'd1;
      end else if (b[7:4] == 4'b1110) begin
        acc_len = SeqThree;
        acc_value = {17'd0, b[3:0]};
        acc_held = 2'd1;
      end else if (b[7:3] == 5'b11110) begin
        acc_len = SeqFour;
        acc_value = {18'd0, b[2:0]};
        acc_held = 2'd1;
      end else begin
        units.push_back(ReplacementUnit);
      end
      // lead byte carrying the end mark
      if (eos && acc_len != SeqNone) begin
        units.push_back(ReplacementUnit);
        clear_sequence();
      end
    end

    // last unit of the byte carries the framing marks
    n_units = (units.size() > MaxUnits) ? MaxUnits : units.size();
    for (k = 0; k < n_units; k++) begin
      rec.code_unit  = units[k];
      rec.run_last   = (k == n_units - 1);
      rec.string_end = (k == n_units - 1) && eos;
      pending_units.push_back(rec);
    end
  endfunction

  // one byte request, with random idle cycles ahead of it
  task automatic send_byte(input logic [7:0] b, input logic eos);
    while ($urandom_range(99) < send_idle_pct) begin
      byte_in.valid <= 1'b0;
      @(posedge clk);
    end
    byte_in.valid         <= 1'b1;
    byte_in.data_byte     <= b;
    byte_in.end_of_string <= eos;
    @(posedge clk);
    while (!byte_in.ready) @(posedge clk);
    transcode_byte(b, eos);
    bytes_sent++;
  endtask

  // n bytes taken from the word, most significant first
  task automatic send_seq(input logic [31:0] word, input int n, input logic eos_last);
    int i;
    for (i = n - 1; i >= 0; i--) send_byte(word[8*i +: 8], eos_last && (i == 0));
  endtask

  // one random character: mostly well-formed, some truncated, some raw noise
  task automatic send_random_char();
    logic [31:0] word;
    int          len;
    int          n;
    int          kind;
    int          i;
    logic        eos;
    word = $urandom;
    kind = $urandom_range(99);
    len  = (kind < 25) ? 1 : (kind < 45) ? 2 : (kind < 65) ? 3 : (kind < 90) ? 4 : 0;
    if (len == 0) begin
      send_seq(word, 1, $urandom_range(9) == 0);
    end else begin
      case (len)
        1: word[7] = 1'b0;
        2: word[15:13] = 3'b110;
        3: word[23:20] = 4'b1110;
        default: begin
          word[31:27] = 5'b11110;
          // keep most planes in range
          if ($urandom_range(3) != 0) word[26:24] = 3'($urandom_range(4));
        end
      endcase
      for (i = 0; i < len - 1; i++) word[8*i+6 +: 2] = 2'b10;
      n = len;
      if (len > 1 && $urandom_range(5) == 0) n = $urandom_range(len - 1, 1);
      eos = ($urandom_range(9) == 0);
      send_seq(word >> (8 * (len - n)), n, eos);
    end
  endtask

  // stop sending and wait until every expected unit has arrived
  task automatic wait_idle();
    int guard;
    byte_in.valid <= 1'b0;
    guard = 0;
    while (pending_units.size() != 0 && guard < 5000) begin
      @(posedge clk);
      guard++;
    end
    if (pending_units.size() != 0) begin
      report_mismatch($sformatf("%0d code units never arrived", pending_units.size()));
      pending_units.delete();
    end
    repeat (6) @(posedge clk);
  endtask

  task automatic test_valid_sequences();
    send_idle_pct = 0;
    stall_pct = 0;
    send_seq(32'h0000007F, 1, 1'b0);
    send_seq(32'h00E282AC, 3, 1'b0);
    send_seq(32'hF09F9880, 4, 1'b1);
    wait_idle();
  endtask

  task automatic test_rejected_values();
    // surrogate, overlong and out of range
    send_seq(32'h00EDA080, 3, 1'b0);
    send_seq(32'h0000C080, 2, 1'b0);
    send_seq(32'hF4908080, 4, 1'b1);
    wait_idle();
  endtask

  task automatic test_broken_sequences();
    // three held bytes broken by a null byte
    send_seq(32'hF09F9800, 4, 1'b0);
    // lone continuation, then an invalid lead
    send_seq(32'h000080FF, 2, 1'b0);
    // truncated at end of string, then a lead carrying the mark
    send_seq(32'h0000E282, 2, 1'b1);
    send_seq(32'h000000C3, 1, 1'b1);
    wait_idle();
  endtask

  task automatic test_random_traffic();
    int send_pcts[4];
    int stall_pcts[4];
    int p;
    int start;
    send_pcts  = '{0, 58, 0, 36};
    stall_pcts = '{0, 0, 58, 36};
    for (p = 0; p < 4; p++) begin
      send_idle_pct = send_pcts[p];
      stall_pct = stall_pcts[p];
      start = bytes_sent;
      while (bytes_sent - start < 15) send_random_char();
      wait_idle();
    end
  endtask

  task automatic test_receiver_hold();
    send_idle_pct = 0;
    stall_pct = 0;
    hold_req = 80;
    repeat (8) send_random_char();
    wait_idle();
  endtask

  task automatic test_sender_pause();
    send_idle_pct = 36;
    stall_pct = 36;
    // sequence left open across an idle pause
    send_seq(32'h00F09F98, 3, 1'b0);
    wait_idle();
    send_seq(32'h00000080, 1, 1'b0);
    repeat (6) send_random_char();
    wait_idle();
  endtask

  // receiver ready, with random stalls and a long hold-off on request
  always @(posedge clk) begin
    if (hold_req > 0) begin
      hold_cnt = hold_req;
      hold_req = 0;
    end
    if (hold_cnt > 0) begin
      hold_cnt--;
      unit_out.ready <= 1'b0;
    end else begin
      unit_out.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // compare each accepted code unit with the oldest expected one
  always @(posedge clk) begin : unit_check
    unit_rec_t want;
    if (!rst && unit_out.valid && unit_out.ready) begin
      if (pending_units.size() == 0) begin
        report_mismatch($sformatf("unexpected code unit %h", unit_out.code_unit));
      end else begin
        want = pending_units.pop_front();
        if (unit_out.code_unit !== want.code_unit)
          report_mismatch($sformatf("code_unit %h, expected %h",
                                    unit_out.code_unit, want.code_unit));
        if (unit_out.run_last !== want.run_last)
          report_mismatch($sformatf("run_last %b, expected %b on unit %h",
                                    unit_out.run_last, want.run_last, want.code_unit));
        if (unit_out.string_end !== want.string_end)
          report_mismatch($sformatf("string_end %b, expected %b on unit %h",
                                    unit_out.string_end, want.string_end, want.code_unit));
      end
    end
  end

  // main sequence
  initial begin
    rst = 1'b1;
    byte_in.valid = 1'b0;
    byte_in.data_byte = 8'h00;
    byte_in.end_of_string = 1'b0;
    unit_out.ready = 1'b0;
    mismatches = 0;
    bytes_sent = 0;
    send_idle_pct = 0;
    stall_pct = 0;
    hold_req = 0;
    hold_cnt = 0;
    clear_sequence();
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_valid_sequences();
    test_rejected_values();
    test_broken_sequences();
    test_random_traffic();
    test_receiver_hold();
    test_sender_pause();

    if (mismatches == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/u2u_pkg.sv
rtl/utf8_byte_if.sv
rtl/utf16_unit_if.sv
rtl/u2u_decode.sv
rtl/u2u_emit.sv
rtl/utf8_to_utf16_transcoder.sv
sim/tb.sv
